>>> sv/move_to_front_search_list_defines.svh
// assertion macros shared by the list logic
`ifndef MOVE_TO_FRONT_SEARCH_LIST_DEFINES_SVH
`define MOVE_TO_FRONT_SEARCH_LIST_DEFINES_SVH

// plain property, checked on every edge out of reset
`define MTFSL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle, consequent in the next
`define MTFSL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/mtfsl_pkg.sv
package mtfsl_pkg;

  localparam int DEPTH_DEFAULT = 16;

  localparam int CMD_W = 2;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;
  localparam int POS_W = 4;
  localparam int LEN_W = 5;

  localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

  localparam logic [ST_W-1:0] ST_DONE     = 2'd0;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd2;

  // per-cell control from the sequencer
  typedef struct packed {
    logic wr;     // load the shared write data
    logic shift;  // take the left neighbour's entry
  } cell_ctl_t;

endpackage

>>> sv/mtfsl_cell.sv
module mtfsl_cell (
  input  logic                              clk,
  input  mtfsl_pkg::cell_ctl_t              ctl,
  input  logic signed [mtfsl_pkg::VAL_W-1:0] wr_data,
  input  logic signed [mtfsl_pkg::VAL_W-1:0] key,
  input  logic signed [mtfsl_pkg::VAL_W-1:0] prev_entry,
  output logic signed [mtfsl_pkg::VAL_W-1:0] entry,
  output logic                              match
);

  logic signed [mtfsl_pkg::VAL_W-1:0] entry_r;
  logic                               match_r;

  // entry storage, no reset: contents only read below the fill count
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      entry_r <= wr_data;
    end else if (ctl.shift) begin
      entry_r <= prev_entry;
    end
    match_r <= (entry_r == key);
  end

  assign entry = entry_r;
  assign match = match_r;

endmodule

>>> sv/mtfsl_locate.sv
`include "move_to_front_search_list_defines.svh"

module mtfsl_locate #(
  parameter int DEPTH = mtfsl_pkg::DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [DEPTH-1:0]           match_vec,
  output logic                       hit,
  output logic [DEPTH-1:0]           below,
  output logic [$clog2(DEPTH)-1:0]   pos
);

  localparam int IDX_W = $clog2(DEPTH);

  logic [DEPTH-1:0] onehot_r;
  logic             hit_r;

  // isolate the first match from the head with one wide add
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      onehot_r <= '0;
      hit_r    <= 1'b0;
    end else begin
      onehot_r <= match_vec & (~match_vec + DEPTH'(1));
      hit_r    <= |match_vec;
    end
  end

  // cells ahead of the match
  assign below = onehot_r - DEPTH'(1);

  always_comb begin
    pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (onehot_r[i]) begin
        pos = pos | IDX_W'(i);
      end
    end
  end

  assign hit = hit_r;

  `MTFSL_ASSERT(a_onehot, $onehot0(onehot_r), "more than one first match")
  `MTFSL_ASSERT(a_hit_agree, hit_r == (|onehot_r), "hit flag disagrees with match vector")
  `MTFSL_ASSERT(a_pos_zero, hit_r || (pos == '0), "position set without a hit")

endmodule

>>> sv/move_to_front_search_list.sv
// Move-to-front list of up to DEPTH signed 32-bit entries, held in a row of cells.
// A transaction is accepted on the rising edge where start is high and busy is low;
// every transaction gives exactly one result, shown for one cycle with out_strobe
// high on the cycle after its work ends. The receiver cannot stall, so it must take
// each result in that cycle. Start, append and the unused command may follow each
// other with no gap; their result appears while the next transaction is accepted.
// A search goes through accept, compare in every cell, pick the first match and
// move it to the head, and holds busy high through the compare, pick and move states;
// its length is set by the registered compare and the first-match stage, not by DEPTH.
// Entries are not cleared by reset, only the fill count, so no clearing pass is needed.
`include "move_to_front_search_list_defines.svh"

module move_to_front_search_list #(
  parameter int DEPTH = mtfsl_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  logic [mtfsl_pkg::CMD_W-1:0]         in_command,
  input  logic signed [mtfsl_pkg::VAL_W-1:0]  in_value,
  // result channel
  output logic                                out_strobe,
  output logic [mtfsl_pkg::ST_W-1:0]          out_status,
  output logic [mtfsl_pkg::POS_W-1:0]         out_position,
  output logic [mtfsl_pkg::LEN_W-1:0]         out_length
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_PICK,
    S_MOVE
  } state_t;

  state_t                               state_r;
  logic [CNT_W-1:0]                     count_r;
  logic signed [mtfsl_pkg::VAL_W-1:0]   key_r;
  logic                                 strobe_r;
  logic [mtfsl_pkg::ST_W-1:0]           status_r;
  logic [mtfsl_pkg::POS_W-1:0]          position_r;
  logic [mtfsl_pkg::LEN_W-1:0]          length_r;

  logic                                 accept;
  logic                                 full;
  logic signed [mtfsl_pkg::VAL_W-1:0]   wr_data;
  mtfsl_pkg::cell_ctl_t                 ctl   [DEPTH];
  logic signed [mtfsl_pkg::VAL_W-1:0]   entry [DEPTH];
  logic [DEPTH-1:0]                     match_raw;
  logic [DEPTH-1:0]                     match_vld;
  logic                                 hit;
  logic [DEPTH-1:0]                     below;
  logic [IDX_W-1:0]                     pos;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);
  assign full   = (count_r == CNT_W'(DEPTH));

  // new values come from the port at accept, the key goes to the head on a move
  assign wr_data = (state_r == S_IDLE) ? in_value : key_r;

  // per-cell control: each cell decides on its own index
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctl[i].wr    = 1'b0;
      ctl[i].shift = 1'b0;
      if (accept && (in_command == mtfsl_pkg::CMD_START) && (i == 0)) begin
        ctl[i].wr = 1'b1;
      end
      if (accept && (in_command == mtfsl_pkg::CMD_APPEND) && !full
          && (count_r == CNT_W'(i))) begin
        ctl[i].wr = 1'b1;
      end
      if ((state_r == S_MOVE) && hit) begin
        if (i == 0) begin
          ctl[i].wr = 1'b1;
        end else begin
          ctl[i].shift = below[(i > 0) ? i - 1 : 0];
        end
      end
    end
  end

  // row of cells, each one fed by its left neighbour, the head by the key
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    mtfsl_cell u_cell (
      .clk        (clk),
      .ctl        (ctl[g]),
      .wr_data    (wr_data),
      .key        (key_r),
      .prev_entry ((g == 0) ? key_r : entry[(g > 0) ? g - 1 : 0]),
      .entry      (entry[g]),
      .match      (match_raw[g])
    );
    // only occupied cells may match, and only in the pick cycle of a search
    assign match_vld[g] = match_raw[g] && (state_r == S_PICK) && (CNT_W'(g) < count_r);
  end

  mtfsl_locate #(
    .DEPTH (DEPTH)
  ) u_locate (
    .clk       (clk),
    .rst_n     (rst_n),
    .match_vec (match_vld),
    .hit       (hit),
    .below     (below),
    .pos       (pos)
  );

  // sequencer, fill count and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            key_r      <= in_value;
            position_r <= '0;
            status_r   <= mtfsl_pkg::ST_DONE;
            length_r   <= mtfsl_pkg::LEN_W'(count_r);
            unique case (in_command)
              mtfsl_pkg::CMD_START: begin
                count_r  <= CNT_W'(1);
                length_r <= mtfsl_pkg::LEN_W'(1);
                strobe_r <= 1'b1;
              end
              mtfsl_pkg::CMD_APPEND: begin
                if (full) begin
                  status_r <= mtfsl_pkg::ST_FULL;
                end else begin
                  count_r  <= count_r + CNT_W'(1);
                  length_r <= mtfsl_pkg::LEN_W'(count_r + CNT_W'(1));
                end
                strobe_r <= 1'b1;
              end
              mtfsl_pkg::CMD_SEARCH: begin
                state_r <= S_CMP;
              end
              default: begin
                // unused command: state untouched, current length reported
                strobe_r <= 1'b1;
              end
            endcase
          end
        end
        S_CMP: begin
          state_r <= S_PICK;
        end
        S_PICK: begin
          state_r <= S_MOVE;
        end
        S_MOVE: begin
          state_r    <= S_IDLE;
          strobe_r   <= 1'b1;
          status_r   <= hit ? mtfsl_pkg::ST_DONE : mtfsl_pkg::ST_NOTFOUND;
          position_r <= hit ? mtfsl_pkg::POS_W'(pos) : '0;
          length_r   <= mtfsl_pkg::LEN_W'(count_r);
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_strobe   = strobe_r;
  assign out_status   = status_r;
  assign out_position = position_r;
  assign out_length   = length_r;

  `MTFSL_ASSERT(a_count_range, count_r <= CNT_W'(DEPTH), "fill count beyond depth")
  `MTFSL_ASSERT_NEXT(a_search_quiet, accept && (in_command == mtfsl_pkg::CMD_SEARCH),
    !out_strobe && busy, "search result too early")
  `MTFSL_ASSERT_NEXT(a_move_result, state_r == S_MOVE, out_strobe && !busy,
    "search finished without a result")
  `MTFSL_ASSERT(a_full_len, !(out_strobe && (out_status == mtfsl_pkg::ST_FULL))
    || (count_r == CNT_W'(DEPTH)), "full status while list has room")

endmodule
